// ===== hw/rtl/psp_pkg.sv =====
`default_nettype none
package psp_pkg;

  localparam int MEM_DEPTH   = 1048576;
  localparam int NUM_SLOTS   = 16;
  localparam int NUM_VOICES  = 8;
  localparam int SAMPLE_BITS = 16;

  localparam int ADDR_W  = $clog2(MEM_DEPTH);
  localparam int PTR_W   = ADDR_W + 1;
  localparam int SIDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int VOICE_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  localparam int REQ_W  = 2;
  localparam int SLOT_W = 4;
  localparam int WORD_W = 16;
  localparam int MIX_W  = 19;

  localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TRIG = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

  typedef struct packed {
    logic               capture;
    logic               load_prev;
    logic               load;
    logic               trig;
    logic               tick_rd;
    logic               push;
    logic [VOICE_W-1:0] voice;
  } cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/psp_if.sv =====
`default_nettype none
interface psp_in_if;
  import psp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic [SLOT_W-1:0]        slot_index;
  logic signed [WORD_W-1:0] sample_word;
  modport source (output valid, req_type, slot_index, sample_word, input ready);
  modport sink (input valid, req_type, slot_index, sample_word, output ready);
endinterface

interface psp_out_if;
  import psp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [MIX_W-1:0] mix_sample;
  logic                    load_dropped;
  modport source (output valid, mix_sample, load_dropped, input ready);
  modport sink (input valid, mix_sample, load_dropped, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/psp_ram.sv =====
`default_nettype none
module psp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ===== hw/rtl/psp_ctrl.sv =====
`default_nettype none
module psp_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic [psp_pkg::REQ_W-1:0] in_type,
  output logic                          in_ready,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output psp_pkg::cmd_t                 cmd
);
  import psp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LPREV, S_LOAD, S_TRIG, S_TICK, S_TLAST, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [VOICE_W-1:0] vcnt_r, vcnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               accept;
  logic               out_free;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    vcnt_nxt      = vcnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.voice     = vcnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          vcnt_nxt    = '0;
          unique case (in_type)
            REQ_LOAD: state_nxt = S_LPREV;
            REQ_TRIG: state_nxt = S_TRIG;
            REQ_TICK: state_nxt = S_TICK;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_LPREV: begin
        cmd.load_prev = 1'b1;
        state_nxt     = S_LOAD;
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_DONE;
      end
      S_TRIG: begin
        cmd.trig  = 1'b1;
        state_nxt = S_DONE;
      end
      S_TICK: begin
        cmd.tick_rd = 1'b1;
        if (vcnt_r == VOICE_W'(NUM_VOICES - 1)) begin
          state_nxt = S_TLAST;
        end else begin
          vcnt_nxt = vcnt_r + 1'b1;
        end
      end
      S_TLAST: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          cmd.push      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcnt_r      <= vcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> out_free)
    else $error("result pushed over an untaken word");

  a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_type == REQ_TICK) |=> (state_r == S_TICK && vcnt_r == '0))
    else $error("tick did not start at voice zero");

  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.load_prev, cmd.load, cmd.trig, cmd.tick_rd, cmd.push}) <= 1)
    else $error("more than one datapath command");
endmodule
`default_nettype wire

// ===== hw/rtl/psp_dp.sv =====
`default_nettype none
module psp_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire psp_pkg::cmd_t                    cmd,
  input  wire logic [psp_pkg::SLOT_W-1:0]       in_slot,
  input  wire logic signed [psp_pkg::WORD_W-1:0] in_word,
  output logic signed [psp_pkg::MIX_W-1:0]      mix_sample,
  output logic                                  load_dropped
);
  import psp_pkg::*;

  logic [SLOT_W-1:0]        slot_r;
  logic signed [WORD_W-1:0] word_r;

  logic [ADDR_W-1:0] slot_start_r  [NUM_SLOTS];
  logic [PTR_W-1:0]  slot_len_r    [NUM_SLOTS];
  logic              slot_loaded_r [NUM_SLOTS];

  logic [PTR_W-1:0]   vptr_r    [NUM_VOICES];
  logic [PTR_W-1:0]   vend_r    [NUM_VOICES];
  logic               vactive_r [NUM_VOICES];
  logic [VOICE_W-1:0] next_voice_r;

  logic [PTR_W-1:0]        prev_end_r;
  logic                    rd_pend_r;
  logic signed [MIX_W-1:0] acc_r;
  logic                    drop_r;
  logic signed [MIX_W-1:0] out_mix_r;
  logic                    out_drop_r;

  logic [SLOT_W-1:0] s_rd;
  logic [SIDX_W-1:0] si;
  logic              slot_ok;
  logic [ADDR_W-1:0] rd_start;
  logic [PTR_W-1:0]  rd_len;
  logic              rd_loaded;
  logic [PTR_W-1:0]  rd_end;
  logic [PTR_W-1:0]  waddr;
  logic              drop;
  logic              we;
  logic [ADDR_W-1:0] new_start;

  logic [VOICE_W-1:0]       vi;
  logic                     play;
  logic [SAMPLE_BITS-1:0]   rdata;
  logic signed [SAMPLE_BITS-1:0] st_word;

  assign s_rd      = cmd.load_prev ? SLOT_W'(slot_r - 1'b1) : slot_r;
  assign si        = SIDX_W'(s_rd);
  assign slot_ok   = (32'(slot_r) < NUM_SLOTS);
  assign rd_start  = slot_start_r[si];
  assign rd_len    = slot_len_r[si];
  assign rd_loaded = slot_loaded_r[si];
  assign rd_end    = PTR_W'(rd_start) + rd_len;
  assign waddr     = rd_loaded ? rd_end : prev_end_r;
  assign drop      = !slot_ok || waddr[ADDR_W];
  assign we        = cmd.load && !drop;
  assign new_start = rd_loaded ? rd_start : prev_end_r[ADDR_W-1:0];
  assign st_word   = SAMPLE_BITS'(word_r);

  assign vi   = cmd.voice;
  assign play = vactive_r[vi] && (vptr_r[vi] != vend_r[vi]);

  psp_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MEM_DEPTH)
  ) u_wave (
    .clk  (clk),
    .we   (we),
    .waddr(waddr[ADDR_W-1:0]),
    .wdata(st_word),
    .raddr(vptr_r[vi][ADDR_W-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      slot_r <= in_slot;
      word_r <= in_word;
    end
    if (cmd.load_prev) begin
      prev_end_r <= (slot_r != '0 && rd_loaded) ? rd_end : '0;
    end
    if (cmd.capture) begin
      acc_r <= '0;
    end else if (rd_pend_r) begin
      acc_r <= acc_r + MIX_W'($signed(rdata));
    end
    if (cmd.capture) begin
      drop_r <= 1'b0;
    end else if (cmd.load) begin
      drop_r <= drop;
    end
    if (cmd.push) begin
      out_mix_r  <= acc_r;
      out_drop_r <= drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_start_r[i]  <= '0;
        slot_len_r[i]    <= '0;
        slot_loaded_r[i] <= 1'b0;
      end
      for (int i = 0; i < NUM_VOICES; i++) begin
        vptr_r[i]    <= '0;
        vend_r[i]    <= '0;
        vactive_r[i] <= 1'b0;
      end
      next_voice_r <= '0;
      rd_pend_r    <= 1'b0;
    end else begin
      rd_pend_r <= cmd.tick_rd && play && !vptr_r[vi][ADDR_W];
      if (we) begin
        slot_loaded_r[si] <= 1'b1;
        slot_start_r[si]  <= new_start;
        slot_len_r[si]    <= rd_loaded ? rd_len + 1'b1 : PTR_W'(1);
      end
      if (cmd.trig && slot_ok) begin
        vactive_r[next_voice_r] <= rd_loaded;
        vptr_r[next_voice_r]    <= rd_loaded ? PTR_W'(rd_start) : '0;
        vend_r[next_voice_r]    <= rd_loaded ? rd_end : '0;
        next_voice_r <= (next_voice_r == VOICE_W'(NUM_VOICES - 1)) ? '0
                                                                  : next_voice_r + 1'b1;
      end
      if (cmd.tick_rd && play) begin
        vptr_r[vi] <= vptr_r[vi] + 1'b1;
      end
    end
  end

  assign mix_sample   = out_mix_r;
  assign load_dropped = out_drop_r;

  a_pend_src: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> $past(cmd.tick_rd))
    else $error("wave read without tick command");

  a_push_settled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !rd_pend_r)
    else $error("result pushed with a read in flight");
endmodule
`default_nettype wire

// ===== hw/rtl/polyphonic_sample_player.sv =====
// Channel  Dir  Payload                                  Handshake
// in_ch    in   req_type, slot_index, sample_word        valid/ready
// out_ch   out  mix_sample, load_dropped                 valid/ready
//
// One word in, one result word out. States: load LPREV, LOAD, DONE; trigger TRIG, DONE;
// unknown request DONE; tick TICK (one wave memory read per voice in turn), TLAST, DONE.
// The next word is taken as soon as the controller is idle, even if the last
// result is still held; a result stalls only when the output holds an untaken word.
// Reset (rst_n low, synchronous) clears slots, voices and handshake state;
// the wave memory is not cleared.
`default_nettype none
module polyphonic_sample_player (
  input  wire logic clk,
  input  wire logic rst_n,
  psp_in_if.sink    in_ch,
  psp_out_if.source out_ch
);
  import psp_pkg::*;

  cmd_t cmd;

  psp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_type  (in_ch.req_type),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .cmd      (cmd)
  );

  psp_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_slot     (in_ch.slot_index),
    .in_word     (in_ch.sample_word),
    .mix_sample  (out_ch.mix_sample),
    .load_dropped(out_ch.load_dropped)
  );
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
module tb_top;
  import psp_pkg::*;

  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;
  localparam int RANDOM_REQS = 625;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic [REQ_W-1:0]         kind;
    logic [SLOT_W-1:0]        slot;
    logic signed [WORD_W-1:0] word;
  } req_word_t;

  typedef struct {
    logic signed [MIX_W-1:0] mix;
    logic                    dropped;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  psp_in_if  in_ch();
  psp_out_if out_ch();

  polyphonic_sample_player DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  req_word_t req_q[$];
  result_t   due_q[$];
  int total_reqs = 0;
  int sent_cnt = 0;
  int accepted_cnt = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int n_load = 0, n_drop = 0, n_trig = 0, n_tick = 0, n_loud = 0, n_none = 0;

  // player state as seen from outside
  logic signed [WORD_W-1:0] wave_mem [int];
  logic [ADDR_W-1:0] slot_base [NUM_SLOTS];
  logic [PTR_W-1:0]  slot_len  [NUM_SLOTS];
  bit                slot_used [NUM_SLOTS];
  logic [PTR_W-1:0]  voice_pos  [NUM_VOICES];
  logic [PTR_W-1:0]  voice_stop [NUM_VOICES];
  bit                voice_on   [NUM_VOICES];
  int unsigned       voice_next;

  function automatic result_t advance_player(req_word_t r);
    result_t res;
    int      s;
    int      v;
    longint  base;
    longint  addr;
    int      mix_sum;
    res.mix = '0;
    res.dropped = 1'b0;
    s = int'(r.slot);
    case (r.kind)
      REQ_LOAD: begin
        if (s >= NUM_SLOTS) begin
          res.dropped = 1'b1;
        end else begin
          if (slot_used[s]) begin
            base = slot_base[s];
          end else if (s > 0 && slot_used[s-1]) begin
            base = longint'(slot_base[s-1]) + longint'(slot_len[s-1]);
          end else begin
            base = 0;
          end
          addr = base + (slot_used[s] ? longint'(slot_len[s]) : 0);
          if (addr >= MEM_DEPTH) begin
            res.dropped = 1'b1;
          end else begin
            wave_mem[int'(addr)] = r.word;
            if (!slot_used[s]) begin
              slot_used[s] = 1'b1;
              slot_base[s] = base[ADDR_W-1:0];
              slot_len[s] = '0;
            end
            slot_len[s] = slot_len[s] + 1'b1;
          end
        end
      end
      REQ_TRIG: begin
        if (s < NUM_SLOTS) begin
          v = voice_next % NUM_VOICES;
          voice_on[v] = slot_used[s];
          voice_pos[v] = slot_used[s] ? PTR_W'(slot_base[s]) : '0;
          voice_stop[v] = slot_used[s] ? PTR_W'(slot_base[s]) + slot_len[s] : '0;
          voice_next = (v + 1) % NUM_VOICES;
        end
      end
      REQ_TICK: begin
        mix_sum = 0;
        for (v = 0; v < NUM_VOICES; v++) begin
          if (voice_on[v] && voice_pos[v] != voice_stop[v]) begin
            if (voice_pos[v] < MEM_DEPTH && wave_mem.exists(int'(voice_pos[v])))
              mix_sum += int'(wave_mem[int'(voice_pos[v])]);
            voice_pos[v] = voice_pos[v] + 1'b1;
          end
        end
        res.mix = mix_sum[MIX_W-1:0];
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic queue_req(logic [REQ_W-1:0] kind, int slot, int word);
    req_word_t r;
    r.kind = kind;
    r.slot = SLOT_W'(slot);
    r.word = WORD_W'(word);
    req_q.push_back(r);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("ERROR t=%0t word %0d: %s got %0d want %0d", $time, n_load + n_trig + n_tick
             + n_none, what, got, want);
  endtask

  // sender and receiver idle shares per phase
  function automatic int idle_share(bit rx);
    if (sent_cnt * 3 < total_reqs) return rx ? 79 : 38;
    if (sent_cnt * 3 < total_reqs * 2) return rx ? 38 : 79;
    return 0;
  endfunction

  always @(posedge clk) begin : drive
    req_word_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (req_q.size() > 0 && $urandom_range(99) >= idle_share(1'b0)) begin
        nxt = req_q.pop_front();
        sent_cnt++;
        in_ch.valid <= 1'b1;
        in_ch.req_type <= nxt.kind;
        in_ch.slot_index <= nxt.slot;
        in_ch.sample_word <= nxt.word;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= idle_share(1'b1));
  end

  always @(posedge clk) begin : watch
    result_t   want;
    req_word_t got_req;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_q.size() == 0) begin
          report_mismatch("unexpected result, mix", int'(out_ch.mix_sample), 0);
        end else begin
          want = due_q.pop_front();
          if (out_ch.mix_sample !== want.mix)
            report_mismatch("mix_sample", int'(out_ch.mix_sample), int'(want.mix));
          if (out_ch.load_dropped !== want.dropped)
            report_mismatch("load_dropped", int'(out_ch.load_dropped), int'(want.dropped));
          if (want.mix != 0) n_loud++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        got_req.kind = in_ch.req_type;
        got_req.slot = in_ch.slot_index;
        got_req.word = in_ch.sample_word;
        want = advance_player(got_req);
        due_q.push_back(want);
        accepted_cnt++;
        case (got_req.kind)
          REQ_LOAD: begin
            n_load++;
            if (want.dropped) n_drop++;
          end
          REQ_TRIG: n_trig++;
          REQ_TICK: n_tick++;
          default: n_none++;
        endcase
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("FAIL polyphonic_sample_player");
      $finish;
    end
  end

  initial begin : stim
    int counted;
    int pick;
    int len;
    int slot;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_NONE;
    in_ch.slot_index = '0;
    in_ch.sample_word = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_base[i] = '0;
      slot_len[i] = '0;
      slot_used[i] = 1'b0;
    end
    for (int i = 0; i < NUM_VOICES; i++) begin
      voice_pos[i] = '0;
      voice_stop[i] = '0;
      voice_on[i] = 1'b0;
    end
    voice_next = 0;

    // directed: empty tick, unloaded trigger, word extremes, overlap, retrigger wrap
    queue_req(REQ_TICK, 0, 0);
    queue_req(REQ_TRIG, 3, 0);
    queue_req(REQ_LOAD, 0, 32767);
    queue_req(REQ_LOAD, 0, -32768);
    queue_req(REQ_LOAD, 0, 0);
    queue_req(REQ_LOAD, 0, -1);
    queue_req(REQ_LOAD, 0, 1);
    queue_req(REQ_LOAD, 1, 16'h5555);
    queue_req(REQ_LOAD, 1, 16'hAAAA);
    queue_req(REQ_TRIG, 0, 0);
    queue_req(REQ_TRIG, 1, 0);
    queue_req(REQ_TICK, 15, 16'hFFFF);
    queue_req(REQ_TICK, 0, 0);
    queue_req(REQ_LOAD, 0, 100);
    queue_req(REQ_LOAD, 3, -2);
    queue_req(REQ_NONE, 15, 16'hFFFF);
    queue_req(REQ_TRIG, 15, 0);
    for (int i = 0; i < 6; i++) queue_req(REQ_TRIG, 0, 0);
    queue_req(REQ_TICK, 0, 0);
    queue_req(REQ_TICK, 0, 0);

    // random bursts: loads into a slot, triggers, tick runs, some noise
    counted = 0;
    while (counted < RANDOM_REQS) begin
      pick = $urandom_range(99);
      slot = $urandom_range(NUM_SLOTS - 1);
      if (pick < 42) begin
        len = $urandom_range(6, 1);
        for (int i = 0; i < len; i++) queue_req(REQ_LOAD, slot, $urandom_range(65535));
        counted += len;
      end else if (pick < 62) begin
        len = $urandom_range(3, 1);
        for (int i = 0; i < len; i++)
          queue_req(REQ_TRIG, $urandom_range(NUM_SLOTS - 1), $urandom_range(65535));
        counted += len;
      end else if (pick < 94) begin
        len = $urandom_range(8, 1);
        for (int i = 0; i < len; i++)
          queue_req(REQ_TICK, $urandom_range(NUM_SLOTS - 1), $urandom_range(65535));
        counted += len;
      end else begin
        queue_req(REQ_NONE, slot, $urandom_range(65535));
        counted += 1;
      end
    end
    total_reqs = req_q.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt < total_reqs) @(posedge clk);
    while (due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d loads (%0d dropped), %0d triggers, %0d ticks", n_load, n_drop,
             n_trig, n_tick);
    $display("with %0d nonzero mixes and %0d unknown requests; %0d mismatches", n_loud, n_none,
             errors);
    if (errors == 0) begin
      $display("PASS polyphonic_sample_player");
    end else begin
      $display("FAIL polyphonic_sample_player");
    end
    $finish;
  end

endmodule
